// ----- rtl/gha_pkg.sv -----
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and constants for the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

  // Fixed field widths of the item ports
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned KID_W  = 11;
  localparam int unsigned SLOT_W = 10;
  localparam int unsigned GEN_W  = 32;
  localparam int unsigned CNT_W  = 11;

  // Last generation a slot may carry; a slot removed at it is retired
  localparam logic [GEN_W-1:0] GEN_MAX   = '1;
  localparam logic [GEN_W-1:0] GEN_FIRST = GEN_W'(1);

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_CREATE      = 2'd0,
    FN_FIND_HANDLE = 2'd1,
    FN_FIND_KEY    = 2'd2,
    FN_REMOVE      = 2'd3
  } func_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // capture item, start table / stack reads
    logic pop;     // stack data valid, read the popped slot
    logic commit;  // write back and load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pop_req;  // create that reuses a slot from the free stack
    logic out_free; // result register can take a new result
  } sts_t;

endpackage

// ----- rtl/gha_ram.sv -----
// ----------------------------------------------------------------------------
// gha_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/gha_ctrl.sv -----
// ----------------------------------------------------------------------------
// gha_ctrl
// Sequencer for one operation: capture, optional stack pop, execute.
// ----------------------------------------------------------------------------
module gha_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  gha_pkg::sts_t sts_i,
  output gha_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_EXEC
  } state_e;

  state_e state_q;

  // Commands decode from the state and the handshake inputs
  assign in_stall_o    = (state_q != ST_IDLE);
  assign cmd_o.accept  = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.pop     = (state_q == ST_POP);
  assign cmd_o.commit  = (state_q == ST_EXEC) && sts_i.out_free;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= sts_i.pop_req ? ST_POP : ST_EXEC;
          end
        end
        ST_POP: begin
          state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/gha_dpath.sv -----
// ----------------------------------------------------------------------------
// gha_dpath
// Slot table, free stack, counters and the result register.
// ----------------------------------------------------------------------------
module gha_dpath #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gha_pkg::cmd_t                 cmd_i,
  output gha_pkg::sts_t                 sts_o,
  input  logic [gha_pkg::FUNC_W-1:0]    func_i,
  input  logic [gha_pkg::KID_W-1:0]     key_id_i,
  input  logic [gha_pkg::GEN_W-1:0]     key_generation_i,
  input  logic [gha_pkg::SLOT_W-1:0]    handle_slot_i,
  input  logic [gha_pkg::GEN_W-1:0]     handle_generation_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic                          ok_o,
  output logic [gha_pkg::SLOT_W-1:0]    out_slot_o,
  output logic [gha_pkg::GEN_W-1:0]     out_slot_generation_o,
  output logic [gha_pkg::KID_W-1:0]     out_key_id_o,
  output logic [gha_pkg::GEN_W-1:0]     out_key_generation_o,
  output logic [gha_pkg::CNT_W-1:0]     live_count_o
);

  localparam int unsigned IW   = $clog2(SLOTS);
  localparam int unsigned CW   = $clog2(SLOTS + 1);
  localparam int unsigned CMPW = (CW > gha_pkg::KID_W) ? CW : gha_pkg::KID_W;
  localparam int unsigned TW   = gha_pkg::GEN_W + 1;

  // Counters
  logic [CW-1:0] hw_q, free_top_q, active_q;
  logic [CW-1:0] hw_d, free_top_d, active_d;

  // Captured item
  gha_pkg::func_e             func_q;
  logic [gha_pkg::GEN_W-1:0]  kgen_q, hgen_q;
  logic                       key_ok_q, hdl_ok_q, pop_q, fresh_q;
  logic [IW-1:0]              slot_q;

  // Result register
  logic                       out_valid_q, ok_q;
  logic [gha_pkg::SLOT_W-1:0] oslot_q;
  logic [gha_pkg::GEN_W-1:0]  ogen_q, okgen_q;
  logic [gha_pkg::KID_W-1:0]  okid_q;
  logic [gha_pkg::CNT_W-1:0]  live_q;

  // Memory ports
  logic                       tbl_we, tbl_re;
  logic [IW-1:0]              tbl_raddr;
  logic [TW-1:0]              tbl_wdata, tbl_rdata;
  logic                       stk_we;
  logic [IW-1:0]              stk_rdata;

  // Execute results
  logic                       res_ok, res_hdl, res_key, push;
  logic [gha_pkg::GEN_W-1:0]  gen_new, res_gen;
  logic                       rd_used;
  logic [gha_pkg::GEN_W-1:0]  rd_gen;
  logic [IW-1:0]              look_idx;
  logic [CMPW-1:0]            kid_w;

  gha_pkg::func_e func_in;
  assign func_in = gha_pkg::func_e'(func_i);

  // Status
  assign sts_o.pop_req  = (func_in == gha_pkg::FN_CREATE) && (free_top_q != '0);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // Table index of the incoming item
  always_comb begin
    unique case (func_in)
      gha_pkg::FN_CREATE:      look_idx = IW'(hw_q);
      gha_pkg::FN_FIND_HANDLE: look_idx = IW'(key_id_i - gha_pkg::KID_W'(1));
      default:                 look_idx = IW'(handle_slot_i);
    endcase
  end

  assign tbl_re    = cmd_i.accept || cmd_i.pop;
  assign tbl_raddr = cmd_i.pop ? stk_rdata : look_idx;

  // Slot table: in-use mark and generation; slots below hw_q are always written
  gha_ram #(.WIDTH(TW), .DEPTH(SLOTS)) u_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (slot_q),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // Free stack, LIFO of reusable slots
  gha_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_stk (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (IW'(free_top_q)),
    .wdata_i (slot_q),
    .re_i    (cmd_i.accept),
    .raddr_i (IW'(free_top_q - CW'(1))),
    .rdata_o (stk_rdata)
  );

  assign rd_used = tbl_rdata[TW-1];
  assign rd_gen  = tbl_rdata[gha_pkg::GEN_W-1:0];

  // Execute: decide the result and the write-back
  always_comb begin
    res_ok    = 1'b0;
    res_hdl   = 1'b0;
    res_key   = 1'b0;
    push      = 1'b0;
    tbl_we    = 1'b0;
    gen_new   = pop_q ? (rd_gen + gha_pkg::GEN_W'(1)) : gha_pkg::GEN_FIRST;
    res_gen   = rd_gen;
    tbl_wdata = {1'b0, rd_gen};
    unique case (func_q)
      gha_pkg::FN_CREATE: begin
        res_ok    = pop_q || fresh_q;
        res_hdl   = res_ok;
        res_key   = res_ok;
        res_gen   = gen_new;
        tbl_wdata = {1'b1, gen_new};
        tbl_we    = cmd_i.commit && res_ok;
      end
      gha_pkg::FN_FIND_HANDLE: begin
        res_ok  = key_ok_q && rd_used && (rd_gen == kgen_q);
        res_hdl = res_ok;
      end
      gha_pkg::FN_FIND_KEY: begin
        res_ok  = hdl_ok_q && rd_used && (rd_gen == hgen_q);
        res_key = res_ok;
      end
      gha_pkg::FN_REMOVE: begin
        res_ok = hdl_ok_q && rd_used && (rd_gen == hgen_q);
        tbl_we = cmd_i.commit && res_ok;
        // slot at the last generation is retired, never reused
        push   = res_ok && (rd_gen != gha_pkg::GEN_MAX) && (free_top_q < CW'(SLOTS));
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  assign stk_we = cmd_i.commit && push;
  assign kid_w  = CMPW'(slot_q) + CMPW'(1);

  // Counter updates
  always_comb begin
    hw_d       = hw_q;
    free_top_d = free_top_q;
    active_d   = active_q;
    if (cmd_i.pop) begin
      free_top_d = free_top_q - CW'(1);
    end
    if (cmd_i.commit) begin
      if (func_q == gha_pkg::FN_CREATE && fresh_q) begin
        hw_d = hw_q + CW'(1);
      end
      if (push) begin
        free_top_d = free_top_q + CW'(1);
      end
      if (func_q == gha_pkg::FN_CREATE && res_ok) begin
        active_d = active_q + CW'(1);
      end else if (func_q == gha_pkg::FN_REMOVE && res_ok && active_q != '0) begin
        active_d = active_q - CW'(1);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q        <= '0;
      free_top_q  <= '0;
      active_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      hw_q       <= hw_d;
      free_top_q <= free_top_d;
      active_q   <= active_d;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item capture and slot index
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q   <= func_in;
      kgen_q   <= key_generation_i;
      hgen_q   <= handle_generation_i;
      key_ok_q <= (key_id_i != '0) && (CMPW'(key_id_i) <= CMPW'(hw_q));
      hdl_ok_q <= (handle_generation_i != '0) && (CMPW'(handle_slot_i) < CMPW'(hw_q));
      pop_q    <= sts_o.pop_req;
      fresh_q  <= (free_top_q == '0) && (hw_q < CW'(SLOTS));
      slot_q   <= look_idx;
    end else if (cmd_i.pop) begin
      slot_q   <= stk_rdata;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      ok_q    <= res_ok;
      oslot_q <= res_hdl ? gha_pkg::SLOT_W'(slot_q) : '0;
      ogen_q  <= res_hdl ? res_gen : '0;
      okid_q  <= res_key ? gha_pkg::KID_W'(kid_w) : '0;
      okgen_q <= res_key ? res_gen : '0;
      live_q  <= gha_pkg::CNT_W'(active_d);
    end
  end

  assign out_valid_o           = out_valid_q;
  assign ok_o                  = ok_q;
  assign out_slot_o            = oslot_q;
  assign out_slot_generation_o = ogen_q;
  assign out_key_id_o          = okid_q;
  assign out_key_generation_o  = okgen_q;
  assign live_count_o          = live_q;

endmodule

// ----- rtl/generational_handle_allocator.sv -----
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Generational slot allocator: create, look up by key or handle, remove.
// ----------------------------------------------------------------------------
//  channel | signals                                           | direction
//  --------+---------------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, func_i, key_id_i,         | to block
//          | key_generation_i, handle_slot_i,                  |
//          | handle_generation_i                               |
//  out     | out_valid_o, out_stall_i, ok_o, out_slot_o,       | from block
//          | out_slot_generation_o, out_key_id_o,              |
//          | out_key_generation_o, live_count_o                |
//
// One item at a time; a create that reuses a slot from the free stack also
// passes the pop state (stack read, then slot table read, registered RAMs).
// The result register lets the next item in while a result is still stalled;
// an item waits in its execute cycle only while the previous result is held.
// Reset is immediate; no clearing pass, the high-water mark bounds every read.
// ----------------------------------------------------------------------------
module generational_handle_allocator #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [gha_pkg::FUNC_W-1:0] func_i,
  input  logic [gha_pkg::KID_W-1:0]  key_id_i,
  input  logic [gha_pkg::GEN_W-1:0]  key_generation_i,
  input  logic [gha_pkg::SLOT_W-1:0] handle_slot_i,
  input  logic [gha_pkg::GEN_W-1:0]  handle_generation_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       ok_o,
  output logic [gha_pkg::SLOT_W-1:0] out_slot_o,
  output logic [gha_pkg::GEN_W-1:0]  out_slot_generation_o,
  output logic [gha_pkg::KID_W-1:0]  out_key_id_o,
  output logic [gha_pkg::GEN_W-1:0]  out_key_generation_o,
  output logic [gha_pkg::CNT_W-1:0]  live_count_o
);

  gha_pkg::cmd_t cmd;
  gha_pkg::sts_t sts;

  // Sequencer
  gha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage and arithmetic
  gha_dpath #(.SLOTS(SLOTS)) u_dpath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .func_i                (func_i),
    .key_id_i              (key_id_i),
    .key_generation_i      (key_generation_i),
    .handle_slot_i         (handle_slot_i),
    .handle_generation_i   (handle_generation_i),
    .out_stall_i           (out_stall_i),
    .out_valid_o           (out_valid_o),
    .ok_o                  (ok_o),
    .out_slot_o            (out_slot_o),
    .out_slot_generation_o (out_slot_generation_o),
    .out_key_id_o          (out_key_id_o),
    .out_key_generation_o  (out_key_generation_o),
    .live_count_o          (live_count_o)
  );

endmodule

// ----- rtl/gha_checker.sv -----
// ----------------------------------------------------------------------------
// gha_checker
// Port-level checks for the generational handle allocator.
// ----------------------------------------------------------------------------
module gha_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic                       ok_o,
  input logic [gha_pkg::SLOT_W-1:0] out_slot_o,
  input logic [gha_pkg::GEN_W-1:0]  out_slot_generation_o,
  input logic [gha_pkg::KID_W-1:0]  out_key_id_o,
  input logic [gha_pkg::GEN_W-1:0]  out_key_generation_o,
  input logic [gha_pkg::CNT_W-1:0]  live_count_o
);

  // A held result stays valid; its ok, slot, key id and live count do not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(ok_o) &&
    $stable(out_slot_o) && $stable(out_key_id_o) && $stable(live_count_o))
    else $error("result changed while stalled");

  // One item in flight: the input stalls right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while one is in flight");

  // A failed operation returns no handle and no key
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> out_slot_o == '0 && out_slot_generation_o == '0 &&
    out_key_id_o == '0 && out_key_generation_o == '0)
    else $error("failed result carries handle or key data");

  // A create returns a matching handle and key
  a_create_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ok_o && out_slot_generation_o != '0 && out_key_generation_o != '0
    |-> out_slot_generation_o == out_key_generation_o &&
        out_key_id_o[gha_pkg::SLOT_W-1:0] == out_slot_o + gha_pkg::SLOT_W'(1))
    else $error("handle and key of a create disagree");

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (.*);
